// ===== hw/rtl/lpt_pkg.sv =====
// Shared types, constants and constant functions of the log-polar tanh pixel map.
// Used by log_polar_tanh_pixel_map and lpt_div; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lpt_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int Q_W              = 16;   // quotient bits of the divider
    localparam int CFG_IDX_W        = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BAND_PERIOD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 1'b1;

    localparam logic [15:0] BAND_PERIOD_RST  = 16'd4096;
    localparam logic [7:0]  REPEAT_COUNT_RST = 8'd1;

    // pi/(2*ln2) and ln2/(4*pi), Q.24
    localparam logic [25:0] C_EXP_SCALE = 26'd38020193;
    localparam logic [19:0] C_LOG_SCALE = 20'd925413;
    // CORDIC start value, inverse gain in Q1.30
    localparam logic [31:0] C_CORDIC_K  = 32'd652032874;

    // atan(2^-i) in turns, 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic              valid;
        logic              bad;
        logic signed [8:0] cnt;
    } t_side;

    // integer square root, bit by bit; only evaluated for constants
    function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] r;
        logic [63:0] b;
        a = a_in;
        r = 64'd0;
        for (int i = 0; i < 32; i++) begin
            b = 64'd1 << (62 - 2 * i);
            if (a >= r + b) begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // 0.5 square-rooted k times, Q.30, each root floored
    function automatic logic [31:0] exp_root(input int k);
        logic [63:0] r;
        r = 64'd1 << 29;
        for (int i = 0; i < 24; i++) begin
            if (i < k) begin
                r = isqrt64(r << 30);
            end
        end
        return r[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lpt_div.sv =====
// Pipelined restoring divider, two numerators over one shared denominator.
// One quotient bit per stage; sideband travels along. Depends on lpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lpt_div #(
    parameter int MAG_W = 47,
    parameter int DEN_W = 33
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic [DEN_W-1:0]              i_den,
    input  wire logic [MAG_W-1:0]              i_num_re,
    input  wire logic [MAG_W-1:0]              i_num_im,
    input  wire logic                          i_neg_im,
    input  wire lpt_pkg::t_side                i_side,
    output logic      [lpt_pkg::Q_W-1:0]       o_quo_re,
    output logic      [lpt_pkg::Q_W-1:0]       o_quo_im,
    output logic                               o_neg_im,
    output lpt_pkg::t_side                     o_side
);
    localparam int QW = lpt_pkg::Q_W;
    localparam int CW = (MAG_W > DEN_W + QW) ? MAG_W : DEN_W + QW;

    logic [CW-1:0]    r_rem_re [0:QW];
    logic [CW-1:0]    r_rem_im [0:QW];
    logic [DEN_W-1:0] r_den    [0:QW];
    logic [QW-1:0]    r_q_re   [0:QW];
    logic [QW-1:0]    r_q_im   [0:QW];
    logic             r_neg    [0:QW];
    lpt_pkg::t_side   r_side   [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0].valid <= 1'b0;
        end else if (i_en) begin
            r_side[0] <= i_side;
        end
        if (i_en) begin
            r_rem_re[0] <= CW'(i_num_re);
            r_rem_im[0] <= CW'(i_num_im);
            r_den[0]    <= i_den;
            r_q_re[0]   <= '0;
            r_q_im[0]   <= '0;
            r_neg[0]    <= i_neg_im;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_step
        localparam int B = QW - 1 - j;
        logic [CW-1:0] trial;
        logic          take_re;
        logic          take_im;
        assign trial   = CW'(r_den[j]) << B;
        assign take_re = r_rem_re[j] >= trial;
        assign take_im = r_rem_im[j] >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[j+1].valid <= 1'b0;
            end else if (i_en) begin
                r_side[j+1] <= r_side[j];
            end
            if (i_en) begin
                r_rem_re[j+1] <= take_re ? r_rem_re[j] - trial : r_rem_re[j];
                r_rem_im[j+1] <= take_im ? r_rem_im[j] - trial : r_rem_im[j];
                r_q_re[j+1]   <= r_q_re[j] | (QW'(take_re) << B);
                r_q_im[j+1]   <= r_q_im[j] | (QW'(take_im) << B);
                r_den[j+1]    <= r_den[j];
                r_neg[j+1]    <= r_neg[j];
            end
        end
    end

    assign o_quo_re = r_q_re[QW];
    assign o_quo_im = r_q_im[QW];
    assign o_neg_im = r_neg[QW];
    assign o_side   = r_side[QW];
endmodule
`default_nettype wire

// ===== hw/rtl/log_polar_tanh_pixel_map.sv =====
// Throughput: one pixel per cycle; every stage advances together and holds
// while a finished result is stalled at the output register.
// Reset: synchronous, active low; clears the valid bits and loads band_period = 4096
// and repeat_count = 1. Datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module log_polar_tanh_pixel_map #(
    parameter int CORDIC_STEPS = lpt_pkg::CORDIC_STEPS_DEF,
    parameter int COORD_WIDTH  = lpt_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lpt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [15:0]                     i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic signed [COORD_WIDTH-1:0]   i_x_coord,
    input  wire logic signed [COORD_WIDTH-1:0]   i_y_coord,
    input  wire logic signed [8:0]               i_inversion_count,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [15:0]                   o_map_real,
    output logic signed [15:0]                   o_map_imag,
    output logic signed [8:0]                    o_out_inversions
);
    localparam int W     = COORD_WIDTH;
    localparam int S     = CORDIC_STEPS;
    localparam int VW    = W + 19;
    localparam int R2W   = 2 * W;
    localparam int MW    = $clog2(R2W);
    localparam int ZW    = 34;
    localparam int MAG_W = 47;
    localparam int DEN_W = 33;
    localparam int QW    = lpt_pkg::Q_W;

    logic [15:0] r_band_period;
    logic [7:0]  r_repeat_count;
    logic        en;
    logic        r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_period  <= lpt_pkg::BAND_PERIOD_RST;
            r_repeat_count <= lpt_pkg::REPEAT_COUNT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == lpt_pkg::CFG_BAND_PERIOD) begin
                r_band_period <= i_cfg_data;
            end else begin
                r_repeat_count <= i_cfg_data[7:0];
            end
        end
    end

    // the whole pipe advances unless a result sits stalled at the output
    assign en         = !r_out_vld || !i_out_stall;
    assign o_in_stall = !en;

    // ---------------- input and squared radius ----------------
    logic signed [W-1:0]   r_p1_x, r_p1_y, r_p2_x, r_p2_y;
    logic [R2W-1:0]        r_p2_r2;
    lpt_pkg::t_side        r_p1_side, r_p2_side;
    logic signed [R2W-1:0] xx, yy;

    assign xx = r_p1_x * r_p1_x;
    assign yy = r_p1_y * r_p1_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_side.valid <= 1'b0;
            r_p2_side.valid <= 1'b0;
        end else if (en) begin
            r_p1_side.valid <= i_in_valid;
            r_p1_side.bad   <= i_inversion_count[8] ||
                               (i_x_coord == '0 && i_y_coord == '0);
            r_p1_side.cnt   <= i_inversion_count;
            r_p2_side       <= r_p1_side;
        end
        if (en) begin
            r_p1_x  <= i_x_coord;
            r_p1_y  <= i_y_coord;
            r_p2_x  <= r_p1_x;
            r_p2_y  <= r_p1_y;
            r_p2_r2 <= R2W'($unsigned(xx)) + R2W'($unsigned(yy));
        end
    end

    // ---------------- vectoring CORDIC and log2 squaring ----------------
    logic signed [VW-1:0] r_vx   [0:S];
    logic signed [VW-1:0] r_vy   [0:S];
    logic [31:0]          r_ang  [0:S];
    logic [30:0]          r_m    [0:S];
    logic [23:0]          r_frac [0:S];
    logic [MW-1:0]        r_msb  [0:S];
    lpt_pkg::t_side       r_vs   [0:S];

    logic signed [VW-1:0] vx_init, vy_init;
    logic [MW-1:0]        msb;
    logic [R2W+29:0]      norm;

    assign vx_init = {{3{r_p2_x[W-1]}}, r_p2_x, 16'b0};
    assign vy_init = {{3{r_p2_y[W-1]}}, r_p2_y, 16'b0};

    always_comb begin
        msb = '0;
        for (int i = 0; i < R2W; i++) begin
            if (r_p2_r2[i]) begin
                msb = MW'(i);
            end
        end
    end

    // place the leading one at bit 30
    assign norm = {r_p2_r2, 30'b0} >> msb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs[0].valid <= 1'b0;
        end else if (en) begin
            r_vs[0] <= r_p2_side;
        end
        if (en) begin
            if (r_p2_x[W-1]) begin
                r_vx[0]  <= -vx_init;
                r_vy[0]  <= -vy_init;
                r_ang[0] <= 32'h8000_0000;
            end else begin
                r_vx[0]  <= vx_init;
                r_vy[0]  <= vy_init;
                r_ang[0] <= 32'h0;
            end
            r_m[0]    <= norm[30:0];
            r_frac[0] <= '0;
            r_msb[0]  <= msb;
        end
    end

    for (genvar j = 0; j < S; j++) begin : g_vec
        localparam logic [31:0] AT = lpt_pkg::ATAN_TURNS[j];
        logic signed [VW-1:0] dx, dy;
        logic [61:0]          sq;
        assign dx = r_vy[j] >>> j;
        assign dy = r_vx[j] >>> j;
        assign sq = {31'b0, r_m[j]} * {31'b0, r_m[j]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs[j+1].valid <= 1'b0;
            end else if (en) begin
                r_vs[j+1] <= r_vs[j];
            end
            if (en) begin
                if (r_vy[j] > 0) begin
                    r_vx[j+1]  <= r_vx[j] + dx;
                    r_vy[j+1]  <= r_vy[j] - dy;
                    r_ang[j+1] <= r_ang[j] + AT;
                end else begin
                    r_vx[j+1]  <= r_vx[j] - dx;
                    r_vy[j+1]  <= r_vy[j] + dy;
                    r_ang[j+1] <= r_ang[j] - AT;
                end
                if (sq[61]) begin
                    r_m[j+1]    <= sq[61:31];
                    r_frac[j+1] <= r_frac[j] | (24'd1 << (23 - j));
                end else begin
                    r_m[j+1]    <= sq[60:30];
                    r_frac[j+1] <= r_frac[j];
                end
                r_msb[j+1] <= r_msb[j];
            end
        end
    end

    // ---------------- scaling of X and Y ----------------
    logic [31:0]        r_q1_angr;
    logic [23:0]        r_q1_pr;
    logic signed [31:0] r_q1_lg;
    logic [31:0]        r_q2_xq;
    logic signed [56:0] r_q2_yp;
    logic [29:0]        r_q3_tq;
    logic signed [61:0] r_q3_ym;
    lpt_pkg::t_side     r_q1_side, r_q2_side, r_q3_side;

    logic [39:0]        angp;
    logic [7:0]         lg_int;
    logic [57:0]        tp;
    logic signed [46:0] yq;
    logic               y_out;

    assign angp   = {8'b0, r_ang[S]} * {32'b0, r_repeat_count};
    assign lg_int = {{(8 - MW){1'b0}}, r_msb[S]} - 8'd24;
    assign tp     = {26'b0, r_q2_xq} * {32'b0, lpt_pkg::C_EXP_SCALE};
    assign yq     = {r_q3_ym[61], r_q3_ym[61:16]} + 47'sd268435456;
    assign y_out  = (yq > 47'sd268435456) || (yq < -47'sd268435456);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_side.valid <= 1'b0;
            r_q2_side.valid <= 1'b0;
            r_q3_side.valid <= 1'b0;
        end else if (en) begin
            r_q1_side <= r_vs[S];
            r_q2_side <= r_q1_side;
            r_q3_side <= r_q2_side;
        end
        if (en) begin
            r_q1_angr <= angp[31:0];
            r_q1_pr   <= {8'b0, r_band_period} * {16'b0, r_repeat_count};
            r_q1_lg   <= {lg_int, r_frac[S]};
            r_q2_xq   <= {16'b0, r_band_period} * {16'b0, r_q1_angr[31:16]};
            r_q2_yp   <= $signed({1'b0, r_q1_pr}) * r_q1_lg;
            r_q3_tq   <= tp[57:28];
            r_q3_ym   <= $signed(r_q2_yp[56:16]) * $signed({1'b0, lpt_pkg::C_LOG_SCALE});
        end
    end

    // ---------------- rotation CORDIC and exp2 product ----------------
    logic signed [ZW-1:0] r_cr [0:S];
    logic signed [ZW-1:0] r_sr [0:S];
    logic signed [ZW-1:0] r_zr [0:S];
    logic [30:0]          r_p  [0:S];
    logic [29:0]          r_tq [0:S];
    lpt_pkg::t_side       r_rs [0:S];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs[0].valid <= 1'b0;
        end else if (en) begin
            r_rs[0].valid <= r_q3_side.valid;
            r_rs[0].cnt   <= r_q3_side.cnt;
            r_rs[0].bad   <= r_q3_side.bad || y_out;
        end
        if (en) begin
            r_cr[0] <= $signed({2'b0, lpt_pkg::C_CORDIC_K});
            r_sr[0] <= '0;
            r_zr[0] <= {yq[ZW-3:0], 2'b0};
            r_p[0]  <= 31'd1 << 30;
            r_tq[0] <= r_q3_tq;
        end
    end

    for (genvar j = 0; j < S; j++) begin : g_rot
        localparam logic [ZW-1:0] AT = ZW'(lpt_pkg::ATAN_TURNS[j]);
        localparam logic [31:0]   RK = lpt_pkg::exp_root(j + 1);
        logic signed [ZW-1:0] dx, dy;
        logic [62:0]          pp;
        assign dx = r_sr[j] >>> j;
        assign dy = r_cr[j] >>> j;
        assign pp = {32'b0, r_p[j]} * {31'b0, RK};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rs[j+1].valid <= 1'b0;
            end else if (en) begin
                r_rs[j+1] <= r_rs[j];
            end
            if (en) begin
                if (!r_zr[j][ZW-1]) begin
                    r_cr[j+1] <= r_cr[j] - dx;
                    r_sr[j+1] <= r_sr[j] + dy;
                    r_zr[j+1] <= r_zr[j] - $signed(AT);
                end else begin
                    r_cr[j+1] <= r_cr[j] + dx;
                    r_sr[j+1] <= r_sr[j] - dy;
                    r_zr[j+1] <= r_zr[j] + $signed(AT);
                end
                r_p[j+1]  <= r_tq[j][23 - j] ? pp[60:30] : r_p[j];
                r_tq[j+1] <= r_tq[j];
            end
        end
    end

    // ---------------- tanh numerators and denominator ----------------
    logic [30:0]          r_f1_w;
    logic [30:0]          r_f1_c;
    logic signed [31:0]   r_f1_s;
    logic [61:0]          r_f2_w2, r_f2_wc;
    logic signed [62:0]   r_f2_ws;
    logic [DEN_W-1:0]     r_f3_den;
    logic [MAG_W-1:0]     r_f3_re, r_f3_im;
    logic                 r_f3_neg;
    lpt_pkg::t_side       r_f1_side, r_f2_side, r_f3_side;

    logic signed [ZW-1:0] one30;
    logic [62:0]          d60;
    logic [60:0]          nre;
    logic signed [63:0]   wsx;
    logic signed [47:0]   tim;
    logic signed [47:0]   mim;

    assign one30 = ZW'(64'd1 << 30);
    assign d60   = (63'd1 << 60) + {1'b0, r_f2_w2} + {r_f2_wc, 1'b0};
    assign nre   = (61'd1 << 60) - r_f2_w2[60:0];
    assign wsx   = {r_f2_ws, 1'b0};
    assign tim   = wsx[63:16];
    assign mim   = tim[47] ? -tim : tim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_side.valid <= 1'b0;
            r_f2_side.valid <= 1'b0;
            r_f3_side.valid <= 1'b0;
        end else if (en) begin
            r_f1_side <= r_rs[S];
            r_f2_side <= r_f1_side;
            r_f3_side <= r_f2_side;
        end
        if (en) begin
            // clamp cos to [0,1] and sin to [-1,1]
            priority if (r_cr[S] < 0) begin
                r_f1_c <= '0;
            end else if (r_cr[S] > one30) begin
                r_f1_c <= 31'd1 << 30;
            end else begin
                r_f1_c <= r_cr[S][30:0];
            end
            priority if (r_sr[S] > one30) begin
                r_f1_s <= 32'sd1073741824;
            end else if (r_sr[S] < -one30) begin
                r_f1_s <= -32'sd1073741824;
            end else begin
                r_f1_s <= r_sr[S][31:0];
            end
            r_f1_w  <= (r_tq[S][29:24] >= 6'd31) ? '0 : (r_p[S] >> r_tq[S][28:24]);
            r_f2_w2 <= {31'b0, r_f1_w} * {31'b0, r_f1_w};
            r_f2_wc <= {31'b0, r_f1_w} * {31'b0, r_f1_c};
            r_f2_ws <= $signed({32'b0, r_f1_w}) * $signed({{31{r_f1_s[31]}}, r_f1_s});
            r_f3_den <= d60[62:30];
            r_f3_re  <= MAG_W'(nre[60:16]);
            r_f3_im  <= mim[MAG_W-1:0];
            r_f3_neg <= tim[47];
        end
    end

    // ---------------- division and output ----------------
    logic [QW-1:0]  quo_re, quo_im;
    logic           neg_im;
    lpt_pkg::t_side div_side;

    lpt_div #(
        .MAG_W (MAG_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_den    (r_f3_den),
        .i_num_re (r_f3_re),
        .i_num_im (r_f3_im),
        .i_neg_im (r_f3_neg),
        .i_side   (r_f3_side),
        .o_quo_re (quo_re),
        .o_quo_im (quo_im),
        .o_neg_im (neg_im),
        .o_side   (div_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= div_side.valid;
        end
        if (en) begin
            if (div_side.bad) begin
                o_map_real       <= '0;
                o_map_imag       <= '0;
                o_out_inversions <= -9'sd1;
            end else begin
                o_map_real       <= $signed(quo_re);
                o_map_imag       <= neg_im ? -$signed(quo_im) : $signed(quo_im);
                o_out_inversions <= div_side.cnt;
            end
        end
    end

    assign o_out_valid = r_out_vld;
endmodule
`default_nettype wire

// ===== hw/rtl/lpt_checker.sv =====
// Port-level checks of log_polar_tanh_pixel_map, attached by bind below.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module lpt_assert (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic signed [15:0] o_map_real,
    input wire logic signed [15:0] o_map_imag,
    input wire logic signed [8:0]  o_out_inversions
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_map_real) &&
        $stable(o_map_imag) && $stable(o_out_inversions))
        else $error("stalled result changed");

    // input side stalls only behind a stalled result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // a dropped pixel carries zero parts
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_inversions == -9'sd1 |-> o_map_real == '0 && o_map_imag == '0)
        else $error("invalid pixel with nonzero result");

    // the only negative count is the invalid mark
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_out_inversions[8] || o_out_inversions == -9'sd1)
        else $error("bad inversion count");
endmodule

bind log_polar_tanh_pixel_map lpt_assert u_lpt_assert (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_map_real       (o_map_real),
    .o_map_imag       (o_map_imag),
    .o_out_inversions (o_out_inversions)
);
`default_nettype wire
